@@ sv/aabb_broadphase_pair_finder_unit_macros.svh @@
// Assertion macros for the AABB broadphase pair finder.
// Included by the top level; no other dependencies.
`ifndef AABB_BROADPHASE_PAIR_FINDER_UNIT_MACROS_SVH
`define AABB_BROADPHASE_PAIR_FINDER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define AABB_BP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define AABB_BP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`else
`define AABB_BP_ASSERT(lbl, clk, rst_n, prop)
`define AABB_BP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/aabb_bp_pkg.sv @@
// Shared types and constants of the AABB broadphase pair finder.
// No dependencies.
package aabb_bp_pkg;

  localparam int MaxBodySlotsDef = 64;
  localparam int MaxPairsDef     = 1024;
  localparam int CoordBitsDef    = 32;

  localparam int IdxW    = 6;
  localparam int CountW  = 7;
  localparam int FieldW  = 32;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // register index, taken from paddr[2]
  localparam logic RegBodiesInUse = 1'b0;

  typedef enum logic [1:0] {
    ActLoad  = 2'd0,
    ActBlock = 2'd1,
    ActStart = 2'd2,
    ActSweep = 2'd3
  } action_e;

  typedef struct packed {
    action_e                   action;
    logic [IdxW-1:0]           body_slot;
    logic [IdxW-1:0]           other_index;
    logic signed [FieldW-1:0]  min_x;
    logic signed [FieldW-1:0]  min_y;
    logic signed [FieldW-1:0]  max_x;
    logic signed [FieldW-1:0]  max_y;
    logic                      body_active;
    logic                      stat_flag;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] first_body;
    logic [IdxW-1:0] second_body;
    logic            pair_valid;
    logic            last;
    logic            cap_hit;
  } out_item_t;

endpackage

@@ sv/aabb_bp_if.sv @@
// Valid/ready channel interfaces for input and result items.
// Depends on aabb_bp_pkg.
interface aabb_bp_in_if;
  logic                 valid;
  logic                 ready;
  aabb_bp_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface aabb_bp_out_if;
  logic                  valid;
  logic                  ready;
  aabb_bp_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

@@ sv/aabb_bp_box_store.sv @@
// Box memory: one entry per body slot, coordinates narrowed to CoordBits.
// Depends on aabb_bp_pkg.
module aabb_bp_box_store #(
  parameter int MaxBodySlots = aabb_bp_pkg::MaxBodySlotsDef,
  parameter int CoordBits    = aabb_bp_pkg::CoordBitsDef,
  parameter int AddrW        = $clog2(MaxBodySlots)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  aabb_bp_pkg::in_item_t     item_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [4*CoordBits-1:0]    rdata_o
);

  localparam int BoxW = 4 * CoordBits;

  logic [BoxW-1:0] box_mem [MaxBodySlots];
  logic [BoxW-1:0] wbox;
  logic [BoxW-1:0] rdata_q;

  // packed as {max_y, max_x, min_y, min_x}, upper bits dropped
  assign wbox = {item_i.max_y[CoordBits-1:0], item_i.max_x[CoordBits-1:0],
                 item_i.min_y[CoordBits-1:0], item_i.min_x[CoordBits-1:0]};

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      box_mem[waddr_i] <= wbox;
    end
    rdata_q <= box_mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/aabb_bp_ovl.sv @@
// Inclusive overlap test of two packed boxes, signed compare.
// Depends on aabb_bp_pkg for its parameter default.
module aabb_bp_ovl #(
  parameter int CoordBits = aabb_bp_pkg::CoordBitsDef
) (
  input  logic [4*CoordBits-1:0] a_i,
  input  logic [4*CoordBits-1:0] b_i,
  output logic                   touch_o
);

  logic signed [CoordBits-1:0] a_minx, a_miny, a_maxx, a_maxy;
  logic signed [CoordBits-1:0] b_minx, b_miny, b_maxx, b_maxy;

  assign a_minx = a_i[0*CoordBits +: CoordBits];
  assign a_miny = a_i[1*CoordBits +: CoordBits];
  assign a_maxx = a_i[2*CoordBits +: CoordBits];
  assign a_maxy = a_i[3*CoordBits +: CoordBits];
  assign b_minx = b_i[0*CoordBits +: CoordBits];
  assign b_miny = b_i[1*CoordBits +: CoordBits];
  assign b_maxx = b_i[2*CoordBits +: CoordBits];
  assign b_maxy = b_i[3*CoordBits +: CoordBits];

  // touching edges count as overlap
  assign touch_o = !(a_maxx < b_minx) && !(b_maxx < a_minx) &&
                   !(a_maxy < b_miny) && !(b_maxy < a_miny);

endmodule

@@ sv/aabb_broadphase_pair_finder_unit.sv @@
// AABB broadphase pair finder, top level: sequencer, flags, blocked-pair memory.
// Depends on aabb_bp_pkg, aabb_bp_if, aabb_bp_box_store, aabb_bp_ovl and the macros header.
//
// Usage:
//   in_i carries items: load body, block pair, start frame, sweep row.
//   out_o carries the result items of a sweep: each overlapping pair (row, j)
//   for j above the row, ascending, last set on the final one; a sweep with
//   no pair gives one empty result (pair_valid low, last high).
//   bodies_in_use is to be written over the APB port only while the block is idle; the block does not enforce it.
// Sequencing:
//   Load and start frame complete on acceptance; a block pair then writes the
//   blocked-pair memory in StBlkWr. A sweep of row i passes StSwInit, then tests
//   each later body in use in StSwTest through the shared overlap unit fed by the
//   box memory read port, then StSwEnd; an out-of-range row goes to StSwEnd
//   directly. in_i.ready is low while a block or sweep item is in progress.
// Reset clears flags, blocked marks, the pair count and bodies_in_use; boxes
//   are undefined until loaded. Each result of a sweep is held back in pend_q
//   until the next one or the sweep end, so last can be set; when out_o stalls,
//   the sweep pauses on the current body until the output register frees up.
`include "aabb_broadphase_pair_finder_unit_macros.svh"

module aabb_broadphase_pair_finder_unit #(
  parameter int MaxBodySlots = aabb_bp_pkg::MaxBodySlotsDef,
  parameter int MaxPairs     = aabb_bp_pkg::MaxPairsDef,
  parameter int CoordBits    = aabb_bp_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  aabb_bp_in_if.sink                        in_i,
  aabb_bp_out_if.source                     out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [aabb_bp_pkg::ApbAddrW-1:0]  paddr,
  input  logic [aabb_bp_pkg::ApbDataW-1:0]  pwdata,
  output logic [aabb_bp_pkg::ApbDataW-1:0]  prdata,
  output logic                              pready
);

  localparam int AW     = $clog2(MaxBodySlots);
  localparam int CntW   = $clog2(MaxPairs + 1);
  localparam int BoxW   = 4 * CoordBits;
  localparam int IdxW   = aabb_bp_pkg::IdxW;
  localparam int CountW = aabb_bp_pkg::CountW;
  localparam logic [CountW-1:0] SlotsC = CountW'(MaxBodySlots);
  localparam logic [CntW-1:0]   CapC   = CntW'(MaxPairs);
  localparam logic [MaxBodySlots-1:0] OneBit = {{(MaxBodySlots-1){1'b0}}, 1'b1};

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StBlkWr  = 5'b00010,
    StSwInit = 5'b00100,
    StSwTest = 5'b01000,
    StSwEnd  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [CountW-1:0] bodies_q, bodies_d;
  logic [CountW-1:0] count;
  logic              cfg_wr;

  // per-body flags and blocked-row valid bits
  logic [MaxBodySlots-1:0] act_q, act_d, stat_q, stat_d, rowv_q, rowv_d;

  // blocked-pair memory
  logic [MaxBodySlots-1:0] blk_mem [MaxBodySlots];
  logic [MaxBodySlots-1:0] blk_rdata_q, blk_wdata;
  logic [AW-1:0]           blk_raddr, blk_waddr;
  logic                    blk_we;

  // sweep datapath
  logic [IdxW-1:0]         row_q, row_d, hi_q, hi_d;
  logic [CountW-1:0]       j_q, j_d, j_inc;
  logic [BoxW-1:0]         rowbox_q, rowbox_d, box_rdata;
  logic [MaxBodySlots-1:0] blkrow_q, blkrow_d;
  logic                    wb_q, wb_d;
  logic [CntW-1:0]         paircnt_q, paircnt_d, paircnt_inc;
  logic                    touch;
  logic [AW-1:0]           box_raddr;
  logic                    box_we;

  // held-back and output results
  aabb_bp_pkg::out_item_t pend_q, pend_d, out_q, out_d;
  logic                   pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic                   can_load;

  // input decode
  logic            in_acc;
  logic [IdxW-1:0] bi, oi, lo, hi;
  logic            load_ok, blk_ok, sweep_in;
  logic [AW-1:0]   row_a, j_a;
  logic            qual, stall;

  // ---------------- APB register ----------------
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign count  = (bodies_q > SlotsC) ? SlotsC : bodies_q;

  always_comb begin
    bodies_d = bodies_q;
    if (cfg_wr && (paddr[2] == aabb_bp_pkg::RegBodiesInUse)) begin
      bodies_d = pwdata[CountW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == aabb_bp_pkg::RegBodiesInUse) begin
      prdata = {{(aabb_bp_pkg::ApbDataW-CountW){1'b0}}, bodies_q};
    end
  end

  // ---------------- input decode ----------------
  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign bi         = in_i.item.body_slot;
  assign oi         = in_i.item.other_index;
  assign lo         = (bi < oi) ? bi : oi;
  assign hi         = (bi < oi) ? oi : bi;
  assign load_ok    = ({1'b0, bi} < SlotsC);
  assign blk_ok     = (lo != hi) && ({1'b0, hi} < SlotsC);
  assign sweep_in   = ({1'b0, bi} < count);

  assign row_a       = row_q[AW-1:0];
  assign j_a         = j_q[AW-1:0];
  assign j_inc       = j_q + CountW'(1);
  assign paircnt_inc = paircnt_q + CntW'(1);
  assign can_load    = !out_v_q || out_o.ready;

  // ---------------- shared units ----------------
  assign box_we = in_acc && (in_i.item.action == aabb_bp_pkg::ActLoad) && load_ok;

  aabb_bp_box_store #(
    .MaxBodySlots (MaxBodySlots),
    .CoordBits    (CoordBits),
    .AddrW        (AW)
  ) u_box_store (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .waddr_i (bi[AW-1:0]),
    .item_i  (in_i.item),
    .raddr_i (box_raddr),
    .rdata_o (box_rdata)
  );

  aabb_bp_ovl #(
    .CoordBits (CoordBits)
  ) u_ovl (
    .a_i     (rowbox_q),
    .b_i     (box_rdata),
    .touch_o (touch)
  );

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rdata_q <= blk_mem[blk_raddr];
  end

  // pair test of the current body j against the swept row
  assign qual = !blkrow_q[j_a] && act_q[row_a] && act_q[j_a] &&
                !(stat_q[row_a] && stat_q[j_a]) && touch && (paircnt_q < CapC);
  assign stall = qual && pend_v_q && !can_load;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    stat_d    = stat_q;
    rowv_d    = rowv_q;
    row_d     = row_q;
    hi_d      = hi_q;
    j_d       = j_q;
    rowbox_d  = rowbox_q;
    blkrow_d  = blkrow_q;
    wb_d      = wb_q;
    paircnt_d = paircnt_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    out_d     = out_q;
    out_v_d   = out_v_q && !out_o.ready;
    blk_we    = 1'b0;
    blk_waddr = row_a;
    blk_wdata = blkrow_q;
    blk_raddr = (in_i.item.action == aabb_bp_pkg::ActBlock) ? lo[AW-1:0] : bi[AW-1:0];
    box_raddr = bi[AW-1:0];

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (in_i.item.action)
            aabb_bp_pkg::ActLoad: begin
              if (load_ok) begin
                act_d[bi[AW-1:0]]  = in_i.item.body_active;
                stat_d[bi[AW-1:0]] = in_i.item.stat_flag;
              end
            end
            aabb_bp_pkg::ActBlock: begin
              if (blk_ok) begin
                row_d   = lo;
                hi_d    = hi;
                state_d = StBlkWr;
              end
            end
            aabb_bp_pkg::ActStart: begin
              rowv_d    = '0;
              paircnt_d = '0;
            end
            aabb_bp_pkg::ActSweep: begin
              row_d    = bi;
              wb_d     = sweep_in;
              pend_v_d = 1'b0;
              state_d  = sweep_in ? StSwInit : StSwEnd;
            end
            default: ;
          endcase
        end
      end

      StBlkWr: begin
        blk_we        = 1'b1;
        blk_wdata     = (rowv_q[row_a] ? blk_rdata_q : '0) | (OneBit << hi_q[AW-1:0]);
        rowv_d[row_a] = 1'b1;
        state_d       = StIdle;
      end

      StSwInit: begin
        rowbox_d  = box_rdata;
        blkrow_d  = rowv_q[row_a] ? blk_rdata_q : '0;
        j_d       = CountW'({1'b0, row_q}) + CountW'(1);
        box_raddr = j_d[AW-1:0];
        state_d   = (j_d < count) ? StSwTest : StSwEnd;
      end

      StSwTest: begin
        box_raddr = stall ? j_a : j_inc[AW-1:0];
        if (!stall) begin
          blkrow_d[j_a] = 1'b1;
          if (qual) begin
            paircnt_d = paircnt_inc;
            if (pend_v_q) begin
              out_d   = pend_q;
              out_v_d = 1'b1;
            end
            pend_d.first_body  = row_q;
            pend_d.second_body = j_q[IdxW-1:0];
            pend_d.pair_valid  = 1'b1;
            pend_d.last        = 1'b0;
            pend_d.cap_hit     = (paircnt_inc >= CapC);
            pend_v_d           = 1'b1;
          end
          j_d = j_inc;
          if (j_inc >= count) begin
            state_d = StSwEnd;
          end
        end
      end

      StSwEnd: begin
        // write back the tested marks; repeats harmlessly while stalled
        if (wb_q) begin
          blk_we        = 1'b1;
          rowv_d[row_a] = 1'b1;
        end
        if (can_load) begin
          if (pend_v_q) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end else begin
            out_d.first_body  = row_q;
            out_d.second_body = '0;
            out_d.pair_valid  = 1'b0;
            out_d.last        = 1'b1;
            out_d.cap_hit     = (paircnt_q >= CapC);
          end
          out_v_d  = 1'b1;
          pend_v_d = 1'b0;
          state_d  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bodies_q  <= '0;
      act_q     <= '0;
      stat_q    <= '0;
      rowv_q    <= '0;
      wb_q      <= 1'b0;
      paircnt_q <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      bodies_q  <= bodies_d;
      act_q     <= act_d;
      stat_q    <= stat_d;
      rowv_q    <= rowv_d;
      wb_q      <= wb_d;
      paircnt_q <= paircnt_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    hi_q     <= hi_d;
    j_q      <= j_d;
    rowbox_q <= rowbox_d;
    blkrow_q <= blkrow_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign out_o.valid = out_v_q;
  assign out_o.item  = out_q;

  // ---------------- assertions ----------------
  `AABB_BP_ASSERT_IMPL(a_pair_order, clk_i, rst_ni, out_v_q && out_q.pair_valid, out_q.first_body < out_q.second_body)
  `AABB_BP_ASSERT(a_cnt_cap, clk_i, rst_ni, paircnt_q <= CapC)
  `AABB_BP_ASSERT_IMPL(a_pend_in_sweep, clk_i, rst_ni, pend_v_q, state_q == StSwTest || state_q == StSwEnd)
  `AABB_BP_ASSERT(a_sweep_busy, clk_i, rst_ni, in_acc && in_i.item.action == aabb_bp_pkg::ActSweep |=> !in_i.ready)

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for the AABB broadphase pair finder: a directed table, then random frames
// and one dense frame that drives the pair count to its cap. Needs aabb_bp_pkg, aabb_bp_if
// and aabb_broadphase_pair_finder_unit.
module testbench;
  import aabb_bp_pkg::*;

  localparam int Slots        = MaxBodySlotsDef;
  localparam int PairCap      = MaxPairsDef;
  localparam int CycleLimit   = 1000000;
  localparam int SettleCycles = 8;
  localparam logic [ApbAddrW-1:0] BodiesInUseAddr = {RegBodiesInUse, 2'b00};

  typedef struct {
    bit                cfg_write;
    logic [CountW-1:0] cfg_value;
    in_item_t          item;
    bit                typed;
    out_item_t         want;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  aabb_bp_in_if  in_ch ();
  aabb_bp_out_if out_ch ();

  aabb_broadphase_pair_finder_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow copy of the block's state
  logic signed [FieldW-1:0] lo_x [Slots];
  logic signed [FieldW-1:0] hi_x [Slots];
  logic signed [FieldW-1:0] lo_y [Slots];
  logic signed [FieldW-1:0] hi_y [Slots];
  logic [1:0]               flags_of [Slots];  // bit 0 active, bit 1 static
  logic [Slots-1:0]         tested [Slots];
  int unsigned              pair_count;
  logic [CountW-1:0]        body_count_reg;

  out_item_t found[$];
  out_item_t pairs_due[$];

  bit send_calm, take_calm;
  int cycles = 0;
  int mismatches = 0;
  int items_sent = 0;
  int pairs_seen = 0;
  int empties_seen = 0;
  int cfg_writes = 0;
  bit cap_seen = 1'b0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycles, pairs_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int active_slots();
    return (body_count_reg > Slots) ? Slots : int'(body_count_reg);
  endfunction

  function automatic bit boxes_overlap(int a, int b);
    return !(hi_x[a] < lo_x[b] || hi_x[b] < lo_x[a] || hi_y[a] < lo_y[b] || hi_y[b] < lo_y[a]);
  endfunction

  // Works out the results of one accepted item into found[] and updates the shadow state.
  task automatic find_pairs(input in_item_t it);
    int row, oth, lo, hi, cnt;
    out_item_t r;
    row = it.body_slot;
    oth = it.other_index;
    cnt = active_slots();
    found.delete();
    case (it.action)
      ActLoad: begin
        lo_x[row] = it.min_x;
        hi_x[row] = it.max_x;
        lo_y[row] = it.min_y;
        hi_y[row] = it.max_y;
        flags_of[row] = {it.stat_flag, it.body_active};
      end
      ActBlock: begin
        lo = (row < oth) ? row : oth;
        hi = (row < oth) ? oth : row;
        if (lo != hi) tested[lo][hi] = 1'b1;
      end
      ActStart: begin
        for (int k = 0; k < Slots; k++) tested[k] = '0;
        pair_count = 0;
      end
      default: begin
        if (row < cnt) begin
          for (int j = row + 1; j < cnt; j++) begin
            if (tested[row][j]) continue;
            tested[row][j] = 1'b1;
            if (!flags_of[row][0] || !flags_of[j][0]) continue;
            if (flags_of[row][1] && flags_of[j][1]) continue;
            if (!boxes_overlap(row, j)) continue;
            // past the cap the pair is still marked, just not emitted
            if (pair_count >= PairCap) continue;
            pair_count++;
            r.first_body  = IdxW'(row);
            r.second_body = IdxW'(j);
            r.pair_valid  = 1'b1;
            r.last        = 1'b0;
            r.cap_hit     = (pair_count >= PairCap);
            found.push_back(r);
          end
        end
        if (found.size() == 0) begin
          r.first_body  = IdxW'(row);
          r.second_body = '0;
          r.pair_valid  = 1'b0;
          r.last        = 1'b1;
          r.cap_hit     = (pair_count >= PairCap);
        end else begin
          r = found.pop_back();
          r.last = 1'b1;
        end
        found.push_back(r);
      end
    endcase
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    find_pairs(it);
    if (typed) pairs_due.push_back(want);
    else foreach (found[k]) pairs_due.push_back(found[k]);
    items_sent++;
  endtask

  // hold off until every pair due has come, then let a trailing block item finish
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_body_count(input logic [CountW-1:0] v);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BodiesInUseAddr;
    pwdata  <= ApbDataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    body_count_reg = v;
    cfg_writes++;
  endtask

  function automatic in_item_t plain(action_e a, int b, int o);
    in_item_t it;
    it = '0;
    it.action = a;
    it.body_slot = IdxW'(b);
    it.other_index = IdxW'(o);
    return it;
  endfunction

  function automatic step_t op_row(action_e a, int b, int o);
    step_t s;
    s.cfg_write = 1'b0;
    s.cfg_value = '0;
    s.item = plain(a, b, o);
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  // sweep whose single empty result is plain to see
  function automatic step_t empty_row(int r);
    step_t s;
    s = op_row(ActSweep, r, 0);
    s.typed = 1'b1;
    s.want.first_body = IdxW'(r);
    s.want.last = 1'b1;
    return s;
  endfunction

  function automatic step_t load_row(int b, logic signed [FieldW-1:0] x0, y0, x1, y1,
                                     bit act, bit stat);
    step_t s;
    s = op_row(ActLoad, b, 0);
    s.item.min_x = x0;
    s.item.min_y = y0;
    s.item.max_x = x1;
    s.item.max_y = y1;
    s.item.body_active = act;
    s.item.stat_flag = stat;
    return s;
  endfunction

  function automatic step_t cfg_row(int v);
    step_t s;
    s = op_row(ActStart, 0, 0);
    s.cfg_write = 1'b1;
    s.cfg_value = CountW'(v);
    return s;
  endfunction

  // mostly small boxes near the origin so that pairs are common
  function automatic in_item_t with_box(input in_item_t it);
    int unsigned shape;
    int cx, cy;
    shape = $urandom_range(0, 7);
    if (shape == 0) begin
      it.min_x = $urandom;
      it.min_y = $urandom;
      it.max_x = $urandom;
      it.max_y = $urandom;
    end else begin
      cx = int'($urandom_range(0, 'h60000)) - 'h30000;
      cy = int'($urandom_range(0, 'h60000)) - 'h30000;
      it.min_x = cx;
      it.max_x = cx + int'($urandom_range(0, 'h20000));
      it.min_y = cy;
      it.max_y = cy + int'($urandom_range(0, 'h20000));
      if (shape == 1) begin
        it.min_x = it.max_x;
        it.max_x = cx;
      end
    end
    it.body_active = ($urandom_range(0, 3) != 0);
    it.stat_flag = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int cnt;
    int unsigned pick;
    cnt = active_slots();
    pick = $urandom_range(0, 19);
    it.min_x = $urandom;
    it.min_y = $urandom;
    it.max_x = $urandom;
    it.max_y = $urandom;
    it.body_active = $urandom_range(0, 1);
    it.stat_flag = $urandom_range(0, 1);
    it.body_slot = (cnt > 0 && $urandom_range(0, 3) != 0) ?
                   IdxW'($urandom_range(0, cnt - 1)) : IdxW'($urandom_range(0, Slots - 1));
    it.other_index = (cnt > 0 && $urandom_range(0, 3) != 0) ?
                     IdxW'($urandom_range(0, cnt - 1)) : IdxW'($urandom_range(0, Slots - 1));
    if (pick < 4) begin
      it.action = ActLoad;
      it = with_box(it);
    end else if (pick < 8) begin
      it.action = ActBlock;
    end else if (pick < 9) begin
      it.action = ActStart;
    end else begin
      it.action = ActSweep;
    end
    return it;
  endfunction

  initial begin : take_results
    out_item_t got, want;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
      stall = take_calm ? 0 : $urandom_range(0, 13);
      repeat (stall) begin
        out_ch.ready <= 1'b0;
        @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      got = out_ch.item;
      if (got.pair_valid) pairs_seen++;
      else empties_seen++;
      if (got.cap_hit) cap_seen = 1'b1;
      if (pairs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing due: %0d,%0d valid %b last %b cap %b",
                   got.first_body, got.second_body, got.pair_valid, got.last, got.cap_hit);
      end else begin
        want = pairs_due.pop_front();
        if (got.first_body !== want.first_body || got.second_body !== want.second_body ||
            got.pair_valid !== want.pair_valid || got.last !== want.last ||
            got.cap_hit !== want.cap_hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d,%0d v%b l%b c%b, got %0d,%0d v%b l%b c%b",
                     want.first_body, want.second_body, want.pair_valid, want.last,
                     want.cap_hit, got.first_body, got.second_body, got.pair_valid,
                     got.last, got.cap_hit);
        end
      end
    end
  end

  initial begin : stimulus
    step_t plan[$];
    int frame_counts[$];
    in_item_t it;
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.item   <= '0;
    out_ch.ready <= 1'b0;
    body_count_reg = '0;
    pair_count = 0;
    for (int k = 0; k < Slots; k++) begin
      flags_of[k] = '0;
      tested[k] = '0;
      lo_x[k] = '0;
      hi_x[k] = '0;
      lo_y[k] = '0;
      hi_y[k] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no body in use after reset: every row is out of range
    plan.push_back(empty_row(0));
    plan.push_back(empty_row(63));
    plan.push_back(cfg_row(4));
    plan.push_back(load_row(0, -'h10000, -'h10000, 'h10000, 'h10000, 1'b1, 1'b0));
    // corner touch with body 0
    plan.push_back(load_row(1, 'h10000, 'h10000, 'h30000, 'h30000, 1'b1, 1'b0));
    plan.push_back(load_row(2, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                            1'b1, 1'b1));
    // inverted in x, static
    plan.push_back(load_row(3, 'h50000, 0, -'h50000, 0, 1'b1, 1'b1));
    plan.push_back(op_row(ActBlock, 1, 0));
    plan.push_back(op_row(ActBlock, 2, 2));
    plan.push_back(op_row(ActSweep, 0, 0));
    plan.push_back(empty_row(0));
    plan.push_back(op_row(ActSweep, 1, 0));
    plan.push_back(empty_row(3));
    plan.push_back(empty_row(9));
    plan.push_back(op_row(ActStart, 0, 0));
    plan.push_back(op_row(ActSweep, 0, 0));
    plan.push_back(load_row(1, 'h10000, 'h10000, 'h30000, 'h30000, 1'b0, 1'b0));
    plan.push_back(op_row(ActStart, 0, 0));
    plan.push_back(op_row(ActSweep, 0, 0));
    plan.push_back(op_row(ActSweep, 2, 0));
    plan.push_back(cfg_row(2));
    plan.push_back(empty_row(0));
    foreach (plan[s]) begin
      if (plan[s].cfg_write) write_body_count(plan[s].cfg_value);
      else send_item(plan[s].item, plan[s].typed, plan[s].want);
    end

    // every slot gets a box before any sweep can read it
    for (int k = 0; k < Slots; k++) begin
      it = with_box(plain(ActLoad, k, $urandom_range(0, Slots - 1)));
      send_item(it, 1'b0, '0);
    end

    frame_counts = {64, 0, 127, 1, 2, 33, 64, 17};
    frame_counts[7] = $urandom_range(3, 63);
    foreach (frame_counts[f]) begin
      write_body_count(CountW'(frame_counts[f]));
      send_item(plain(ActStart, 0, 0), 1'b0, '0);
      repeat (12) begin
        if ($urandom_range(0, 14) == 0) drain_results();
        send_item(random_item(), 1'b0, '0);
      end
    end

    // crowded frame: far more overlapping pairs than the cap allows
    write_body_count(CountW'(Slots));
    for (int k = 0; k < Slots; k++) begin
      it = plain(ActLoad, k, 0);
      it.min_x = -int'($urandom_range('h10000, 'h20000));
      it.min_y = -int'($urandom_range('h10000, 'h20000));
      it.max_x = int'($urandom_range('h10000, 'h20000));
      it.max_y = int'($urandom_range('h10000, 'h20000));
      it.body_active = 1'b1;
      it.stat_flag = ($urandom_range(0, 7) == 0);
      send_item(it, 1'b0, '0);
    end
    send_item(plain(ActStart, 0, 0), 1'b0, '0);
    for (int k = 0; k < Slots; k++) send_item(plain(ActSweep, k, 0), 1'b0, '0);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (pairs_due.size() != 0) begin
      mismatches += pairs_due.size();
      $display("%0d expected results never came", pairs_due.size());
    end
    $display("%0d items sent over %0d register writes, %0d cycles", items_sent, cfg_writes,
             cycles);
    $display("%0d pairs and %0d empty rows checked, pair cap reached: %0b, %0d mismatches",
             pairs_seen, empties_seen, cap_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
